// ----- src/spq_pkg.sv -----
// Shared types and codes for the severity priority queue.
`default_nettype none

package spq_pkg;

    // One stored entry: severity, arrival key, identifier
    typedef struct packed {
        logic [7:0]  sev;
        logic [31:0] key;
        logic [15:0] ident;
    } t_entry;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_POPPED   = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_FULL     = 2'd3
    } t_status;

    // Command codes on the mode input
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

endpackage

`default_nettype wire

// ----- src/spq_mem.sv -----
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module spq_mem import spq_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_entry             o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read every cycle; the read data is registered and shows the cycle after
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- src/spq_ctrl.sv -----
// Queue sequencer: insert, scan for the most urgent entry, close the gap.
`default_nettype none

module spq_ctrl import spq_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic          i_mode,
    input  wire t_entry        i_entry,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output t_entry             o_wr_data,
    output logic [AW-1:0]      o_rd_addr,
    input  wire t_entry        i_rd_data,
    output logic               o_valid,
    output t_status            o_status,
    output t_entry             o_result,
    output logic [CW-1:0]      o_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_best_idx, n_best_idx;
    t_entry          r_best, n_best;
    logic            r_valid, n_valid;
    t_status         r_status, n_status;
    t_entry          r_result, n_result;
    logic [CW-1:0]   r_occ, n_occ;

    logic [CW-1:0]   cnt_m1;
    logic            at_last;
    logic            take;
    t_entry          cur_best;
    logic [AW-1:0]   cur_idx;

    // Compare the arriving entry against the best so far
    assign cnt_m1  = r_count - CW'(1);
    assign at_last = (CW'(r_idx) == cnt_m1);
    assign take    = (r_idx == '0)
                  || (i_rd_data.sev > r_best.sev)
                  || ((i_rd_data.sev == r_best.sev) && (i_rd_data.key < r_best.key));
    assign cur_best = take ? i_rd_data : r_best;
    assign cur_idx  = take ? r_idx : r_best_idx;

    // Next state, memory accesses and result
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_result   = r_result;
        n_occ      = r_occ;
        o_wr_en    = 1'b0;
        o_wr_addr  = AW'(r_count);
        o_wr_data  = i_entry;
        o_rd_addr  = r_idx + AW'(1);

        case (r_state)
            S_IDLE: begin
                o_rd_addr = '0;
                if (start) begin
                    n_valid  = 1'b1;
                    n_result = '0;
                    n_occ    = r_count;
                    if (i_mode == MODE_POP) begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_valid = 1'b0;
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = STAT_FULL;
                        end else begin
                            o_wr_en  = 1'b1;
                            n_count  = r_count + CW'(1);
                            n_occ    = r_count + CW'(1);
                            n_status = STAT_INSERTED;
                        end
                    end
                end
            end

            S_SCAN: begin
                n_best     = cur_best;
                n_best_idx = cur_idx;
                n_idx      = r_idx + AW'(1);
                if (at_last) begin
                    if (CW'(cur_idx) == cnt_m1) begin
                        // Winner is the tail entry: nothing to move
                        n_valid  = 1'b1;
                        n_status = STAT_POPPED;
                        n_result = cur_best;
                        n_count  = cnt_m1;
                        n_occ    = cnt_m1;
                        n_state  = S_IDLE;
                    end else begin
                        o_rd_addr = cur_idx + AW'(1);
                        n_idx     = cur_idx + AW'(1);
                        n_state   = S_SHIFT;
                    end
                end
            end

            S_SHIFT: begin
                // Move each entry behind the winner down by one
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx - AW'(1);
                o_wr_data = i_rd_data;
                n_idx     = r_idx + AW'(1);
                if (at_last) begin
                    n_valid  = 1'b1;
                    n_status = STAT_POPPED;
                    n_result = r_best;
                    n_count  = cnt_m1;
                    n_occ    = cnt_m1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_idx      <= n_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_status   <= n_status;
        r_result   <= n_result;
        r_occ      <= n_occ;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_result = r_result;
    assign o_count  = r_occ;

endmodule

`default_nettype wire

// ----- src/severity_priority_queue_unit.sv -----
// Top level of the severity priority queue with a linear-scan pop.
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ------------------------------------------------
//  command   start / busy           i_mode, i_severity, i_arrival_key, i_entry_id
//  result    o_valid (1-cycle)      o_status, o_out_severity, o_out_arrival,
//                                   o_out_id, o_occupancy
//
//  An insert, a pop on empty and a dropped insert leave busy low, and the result
//  shows the next cycle. A pop with N held entries and the winner at position W
//  scans all N entries through the read port of the entry store, then closes
//  the gap by moving the N-1-W entries behind it down, one per cycle; busy is high
//  for that span. The result strobe lasts one cycle and cannot be held off.
//  Synchronous reset empties the queue; the store contents need no clearing.
`default_nettype none

module severity_priority_queue_unit import spq_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_severity,
    input  wire logic [31:0] i_arrival_key,
    input  wire logic [15:0] i_entry_id,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [7:0]       o_out_severity,
    output logic [31:0]      o_out_arrival,
    output logic [15:0]      o_out_id,
    output logic [6:0]       o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          in_entry;
    t_entry          wr_data;
    t_entry          rd_data;
    t_entry          result;
    t_status         status;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic [CW-1:0]   count;
    logic [CW+6:0]   occ_ext;

    // Pack the command fields into one entry
    assign in_entry.sev   = i_severity;
    assign in_entry.key   = i_arrival_key;
    assign in_entry.ident = i_entry_id;

    spq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_mode    (i_mode),
        .i_entry   (in_entry),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_valid   (o_valid),
        .o_status  (status),
        .o_result  (result),
        .o_count   (count)
    );

    spq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Unpack the result; occupancy wraps to seven bits
    assign occ_ext        = {7'd0, count};
    assign o_status       = status;
    assign o_out_severity = result.sev;
    assign o_out_arrival  = result.key;
    assign o_out_id       = result.ident;
    assign o_occupancy    = occ_ext[6:0];

endmodule

`default_nettype wire

// ----- tb/sv/severity_priority_queue_unit_test.sv -----
// Self-checking testbench for the severity priority queue: directed corners, then random traffic.
`timescale 1ns / 1ps

module severity_priority_queue_unit_test import spq_pkg::*;;

    localparam int QUEUE_DEPTH = 64;

    // One result as it shows on the output ports
    typedef struct packed {
        t_status     status;
        logic [7:0]  sev;
        logic [31:0] key;
        logic [15:0] ident;
        logic [6:0]  occ;
    } t_result;

    // Scoreboard: mirrors the held entries and queues the result each item must give
    class queue_scoreboard;
        t_entry      held_entries[$];
        t_result     pending_results[$];
        int unsigned mismatches;
        int unsigned depth;

        function new(int unsigned depth_i);
            depth = depth_i;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // Apply one accepted item to the mirror and queue its result
        function void note_command(logic mode, t_entry cmd);
            t_result     res;
            int unsigned best;
            res.status = STAT_INSERTED;
            res.sev    = '0;
            res.key    = '0;
            res.ident  = '0;
            if (mode == MODE_INSERT) begin
                if (held_entries.size() >= depth) begin
                    res.status = STAT_FULL;
                end else begin
                    held_entries.push_back(cmd);
                end
            end else if (held_entries.size() == 0) begin
                res.status = STAT_EMPTY;
            end else begin
                // Highest severity wins, then smaller key, then earlier insertion
                best = 0;
                for (int unsigned i = 1; i < held_entries.size(); i++) begin
                    if (held_entries[i].sev > held_entries[best].sev ||
                        (held_entries[i].sev == held_entries[best].sev &&
                         held_entries[i].key < held_entries[best].key)) begin
                        best = i;
                    end
                end
                res.status = STAT_POPPED;
                res.sev    = held_entries[best].sev;
                res.key    = held_entries[best].key;
                res.ident  = held_entries[best].ident;
                held_entries.delete(best);
            end
            res.occ = 7'(held_entries.size());
            pending_results.push_back(res);
        endfunction

        // Compare one strobed result against the oldest queued one
        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none pending: status %0d sev %h key %h id %h occ %0d",
                             $realtime, got.status, got.sev, got.key, got.ident, got.occ);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch", $realtime);
                    $display("  expected status %0d sev %h key %h id %h occ %0d",
                             want.status, want.sev, want.key, want.ident, want.occ);
                    $display("  actual   status %0d sev %h key %h id %h occ %0d",
                             got.status, got.sev, got.key, got.ident, got.occ);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_mode;
    logic [7:0]  i_severity;
    logic [31:0] i_arrival_key;
    logic [15:0] i_entry_id;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_out_severity;
    logic [31:0] o_out_arrival;
    logic [15:0] o_out_id;
    logic [6:0]  o_occupancy;

    queue_scoreboard sb;
    t_result         seen;

    severity_priority_queue_unit #(.DEPTH(QUEUE_DEPTH)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_severity     (i_severity),
        .i_arrival_key  (i_arrival_key),
        .i_entry_id     (i_entry_id),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_severity (o_out_severity),
        .o_out_arrival  (o_out_arrival),
        .o_out_id       (o_out_id),
        .o_occupancy    (o_occupancy)
    );

    // Run the clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Check every strobed result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            seen.status = t_status'(o_status);
            seen.sev    = o_out_severity;
            seen.key    = o_out_arrival;
            seen.ident  = o_out_id;
            seen.occ    = o_occupancy;
            sb.check_result(seen);
        end
    end

    // Present one item, hold it until accepted, then note it
    task automatic issue_command(input logic mode, input t_entry cmd, input int unsigned idle_pct);
        int unsigned gap;
        gap = 0;
        while (gap < 8 && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_mode        <= mode;
        i_severity    <= cmd.sev;
        i_arrival_key <= cmd.key;
        i_entry_id    <= cmd.ident;
        do @(posedge i_clk); while (busy);
        sb.note_command(mode, cmd);
    endtask

    // Random items; severities and keys often clustered to force ties
    task automatic run_phase(input int unsigned n_items, input int unsigned idle_pct,
                             input int unsigned insert_pct);
        t_entry cmd;
        logic   mode;
        for (int unsigned n = 0; n < n_items; n++) begin
            mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_POP;
            case ($urandom_range(0, 7))
                0:       cmd.sev = 8'h00;
                1:       cmd.sev = 8'hFF;
                2, 3, 4: cmd.sev = 8'(100 + $urandom_range(0, 2));
                default: cmd.sev = 8'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0:       cmd.key = 32'h0000_0000;
                1:       cmd.key = 32'hFFFF_FFFF;
                2, 3:    cmd.key = 32'($urandom_range(0, 3));
                default: cmd.key = $urandom;
            endcase
            cmd.ident = 16'($urandom);
            issue_command(mode, cmd, idle_pct);
        end
    endtask

    // Reset, directed corners, random phases, drain and verdict
    initial begin
        int unsigned guard;
        sb            = new(QUEUE_DEPTH);
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_mode        <= MODE_INSERT;
        i_severity    <= '0;
        i_arrival_key <= '0;
        i_entry_id    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pop on empty, then ties on severity and on key, then extremes, then pops past empty
        issue_command(MODE_POP,    t_entry'{8'hFF, 32'hFFFF_FFFF, 16'hFFFF}, 0);
        issue_command(MODE_INSERT, t_entry'{8'd5,  32'd10,        16'd1},    0);
        issue_command(MODE_INSERT, t_entry'{8'd5,  32'd7,         16'd2},    0);
        issue_command(MODE_INSERT, t_entry'{8'd5,  32'd7,         16'd3},    0);
        issue_command(MODE_INSERT, t_entry'{8'hFF, 32'hFFFF_FFFF, 16'hFFFF}, 0);
        issue_command(MODE_INSERT, t_entry'{8'h00, 32'h0000_0000, 16'h0000}, 0);
        issue_command(MODE_INSERT, t_entry'{8'hFF, 32'h0000_0000, 16'hAAAA}, 0);
        issue_command(MODE_INSERT, t_entry'{8'hAA, 32'h5555_5555, 16'h5555}, 0);
        issue_command(MODE_INSERT, t_entry'{8'h55, 32'hAAAA_AAAA, 16'hAAAA}, 0);
        for (int k = 0; k < 9; k++)
            issue_command(MODE_POP, t_entry'{8'($urandom), $urandom, 16'($urandom)}, 0);
        issue_command(MODE_INSERT, t_entry'{8'h80, 32'h8000_0000, 16'h8000}, 0);
        issue_command(MODE_POP,    t_entry'{8'h00, 32'h0000_0000, 16'h0000}, 0);

        // Fill past full, then mixed traffic under several sender idle rates
        run_phase(200, 0, 75);
        run_phase(300, 68, 50);

        // Hold off until every pending result has come
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);

        run_phase(200, 14, 30);
        run_phase(400, 14, 55);
        run_phase(350, 0, 50);

        // Drain and let any stray result show
        start <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 100_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (2 * QUEUE_DEPTH + 8) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- severity_priority_queue_unit.f -----
src/spq_pkg.sv
src/spq_mem.sv
src/spq_ctrl.sv
src/severity_priority_queue_unit.sv
tb/sv/severity_priority_queue_unit_test.sv
